// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMP(label, clk, rstn, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |-> (rhs)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NXT(label, clk, rstn, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |=> (rhs)) \
    else $error("assertion failed");

`endif

// ===== design/dtgc_pkg.sv =====
// ----------------------------------------------------------------------------
// dtgc_pkg
// Types, constants and command codes of the distance-two colouring unit.
// ----------------------------------------------------------------------------
package dtgc_pkg;

  localparam int unsigned DTGC_MAX_VERTICES = 1024;
  localparam int unsigned DTGC_MAX_EDGES    = 8192;
  localparam int unsigned DTGC_WINDOW       = 32;

  localparam int unsigned RS_W     = 14;
  localparam int unsigned COLOR_W  = 11;
  localparam int unsigned VTX_W    = 10;
  localparam logic [COLOR_W-1:0] COLOR_NONE = '1;
  localparam logic [COLOR_W-1:0] COLOR_MAX  = 11'd1023;

  typedef enum logic [2:0] {
    REQ_WR_ROW   = 3'd0,
    REQ_WR_NB    = 3'd1,
    REQ_WR_COLOR = 3'd2,
    REQ_COLOR    = 3'd3,
    REQ_RD_COLOR = 3'd4
  } dtgc_req_e;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_COLOR,
    KIND_RESULT
  } dtgc_kind_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ACCEPT,
    OP_RS_U1,
    OP_BOUNDS1,
    OP_NB1,
    OP_NB1_DATA,
    OP_V_COLOR,
    OP_RS_V1,
    OP_BOUNDS2,
    OP_NB2,
    OP_NB2_DATA,
    OP_W_COLOR,
    OP_NEXT_V,
    OP_WINDOW,
    OP_EMIT
  } dtgc_op_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RS_U1,
    ST_BOUNDS1,
    ST_L1,
    ST_L1D,
    ST_VC,
    ST_RSV1,
    ST_BOUNDS2,
    ST_L2,
    ST_L2D,
    ST_WC,
    ST_WIN,
    ST_EMIT
  } dtgc_state_e;

  typedef struct packed {
    dtgc_kind_e in_kind;
    logic       clr_last;
    logic       iv_lt_hi;
    logic       iw_lt_hi;
    logic       nb_valid;
    logic       nb_is_u;
    logic       win_advance;
    logic       out_free;
  } dtgc_status_t;

endpackage

// ===== design/dtgc_req_if.sv =====
// ----------------------------------------------------------------------------
// dtgc_req_if
// Request channel: valid/ready handshake with the request word.
// ----------------------------------------------------------------------------
interface dtgc_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic [13:0]        index;
  logic signed [14:0] value;
  logic               last;

  modport source (output valid, output req_type, output index, output value,
                  output last, input ready);
  modport sink   (input valid, input req_type, input index, input value,
                  input last, output ready);
endinterface

// ===== design/dtgc_res_if.sv =====
// ----------------------------------------------------------------------------
// dtgc_res_if
// Result channel: valid/ready handshake with the result word.
// ----------------------------------------------------------------------------
interface dtgc_res_if;
  logic               valid;
  logic               ready;
  logic [9:0]         vertex;
  logic signed [10:0] color;
  logic               batch_done;

  modport source (output valid, output vertex, output color, output batch_done,
                  input ready);
  modport sink   (input valid, input vertex, input color, input batch_done,
                  output ready);
endinterface

// ===== design/dtgc_ctrl.sv =====
// ----------------------------------------------------------------------------
// dtgc_ctrl
// Sequencer: steps the datapath through the clearing pass and the walks.
// ----------------------------------------------------------------------------
module dtgc_ctrl import dtgc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  dtgc_status_t st_i,
  output dtgc_op_e     op_o
);

  dtgc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    op_o       = OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        op_o = OP_CLEAR;
        if (st_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_o = OP_ACCEPT;
          case (st_i.in_kind)
            KIND_COLOR:  state_d = ST_RS_U1;
            KIND_RESULT: state_d = ST_EMIT;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_RS_U1: begin
        op_o    = OP_RS_U1;
        state_d = ST_BOUNDS1;
      end
      ST_BOUNDS1: begin
        op_o    = OP_BOUNDS1;
        state_d = ST_L1;
      end
      ST_L1: begin
        if (st_i.iv_lt_hi) begin
          op_o    = OP_NB1;
          state_d = ST_L1D;
        end else begin
          state_d = ST_WIN;
        end
      end
      ST_L1D: begin
        op_o    = OP_NB1_DATA;
        state_d = st_i.nb_valid ? ST_VC : ST_L1;
      end
      ST_VC: begin
        op_o    = OP_V_COLOR;
        state_d = ST_RSV1;
      end
      ST_RSV1: begin
        op_o    = OP_RS_V1;
        state_d = ST_BOUNDS2;
      end
      ST_BOUNDS2: begin
        op_o    = OP_BOUNDS2;
        state_d = ST_L2;
      end
      ST_L2: begin
        if (st_i.iw_lt_hi) begin
          op_o    = OP_NB2;
          state_d = ST_L2D;
        end else begin
          op_o    = OP_NEXT_V;
          state_d = ST_L1;
        end
      end
      ST_L2D: begin
        op_o    = OP_NB2_DATA;
        state_d = (st_i.nb_valid && !st_i.nb_is_u) ? ST_WC : ST_L2;
      end
      ST_WC: begin
        op_o    = OP_W_COLOR;
        state_d = ST_L2;
      end
      ST_WIN: begin
        op_o    = OP_WINDOW;
        state_d = st_i.win_advance ? ST_L1 : ST_EMIT;
      end
      ST_EMIT: begin
        if (st_i.out_free) begin
          op_o    = OP_EMIT;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

endmodule

// ===== design/dtgc_dp.sv =====
// ----------------------------------------------------------------------------
// dtgc_dp
// Datapath: graph and colour memories, walk counters, window mask, result.
// ----------------------------------------------------------------------------
module dtgc_dp import dtgc_pkg::*; #(
  parameter int unsigned MaxVertices = DTGC_MAX_VERTICES,
  parameter int unsigned MaxEdges    = DTGC_MAX_EDGES,
  parameter int unsigned Window      = DTGC_WINDOW
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dtgc_op_e                  op_i,
  input  logic [2:0]                req_type_i,
  input  logic [13:0]               index_i,
  input  logic signed [14:0]        value_i,
  input  logic                      last_i,
  output dtgc_status_t              st_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [VTX_W-1:0]          vertex_o,
  output logic signed [COLOR_W-1:0] color_o,
  output logic                      batch_done_o
);

  localparam int unsigned VW = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int unsigned RW = $clog2(MaxVertices + 1);
  localparam int unsigned EW = (MaxEdges > 1) ? $clog2(MaxEdges) : 1;
  localparam int unsigned CW = $clog2(MaxEdges + 1);
  localparam int unsigned PW = $clog2(Window);
  localparam int unsigned NW = VW + 1;

  function automatic logic [31:0] min32(input logic [31:0] a, input logic [31:0] b);
    min32 = (a < b) ? a : b;
  endfunction

  // Memories and their registered read data.
  logic [RS_W-1:0]    rs_mem [MaxVertices+1];
  logic [NW-1:0]      nb_mem [MaxEdges];
  logic [COLOR_W-1:0] col_mem [MaxVertices];
  logic [RS_W-1:0]    rs_rd_q;
  logic [NW-1:0]      nb_rd_q;
  logic [COLOR_W-1:0] col_rd_q;

  logic               rs_we, rs_re, nb_we, nb_re, col_we, col_re;
  logic [RW-1:0]      rs_wa, rs_ra;
  logic [EW-1:0]      nb_wa, nb_ra;
  logic [VW-1:0]      col_wa, col_ra;
  logic [RS_W-1:0]    rs_wd;
  logic [NW-1:0]      nb_wd;
  logic [COLOR_W-1:0] col_wd;

  // Walk state.
  logic [VW-1:0]      u_q, v_q, clr_cnt_q;
  logic [RS_W-1:0]    lo_raw_q;
  logic [CW-1:0]      iv_q, lo1_q, hi1_q, iw_q, hi2_q;
  logic [COLOR_W-1:0] low_q;
  logic [Window-1:0]  mask_q;
  logic [VTX_W-1:0]   vtx_q;
  logic               batch_q, from_mem_q, out_valid_q;
  logic [COLOR_W-1:0] res_q;

  // Decoded request.
  logic        lt_v, lt_r, lt_e, val_nb_ok;
  logic [31:0] idx32, val32;
  assign idx32     = 32'(index_i);
  assign val32     = 32'(value_i[13:0]);
  assign lt_v      = idx32 < MaxVertices;
  assign lt_r      = idx32 < (MaxVertices + 1);
  assign lt_e      = idx32 < MaxEdges;
  assign val_nb_ok = !value_i[14] && (val32 < MaxVertices);

  // Window marking from the colour just read.
  logic [11:0]       cdiff;
  logic [Window-1:0] mark;
  assign cdiff = {1'b0, col_rd_q} - {1'b0, low_q};
  assign mark = (!col_rd_q[COLOR_W-1] && !cdiff[11]) ? (Window'(1) << cdiff) : '0;

  logic [PW-1:0] pick;
  logic          full;
  logic [11:0]   cand, next_low;
  always_comb begin
    pick = '0;
    for (int k = Window - 1; k >= 0; k--) begin
      if (!mask_q[k]) pick = PW'(k);
    end
  end
  assign full     = &mask_q;
  assign cand     = 12'(low_q) + 12'(pick);
  assign next_low = 12'(low_q) + 12'(Window);

  logic [COLOR_W-1:0] final_color;
  assign final_color = (full || cand > 12'(COLOR_MAX)) ? COLOR_MAX : cand[COLOR_W-1:0];

  logic [31:0] b32;
  assign b32 = min32(32'(rs_rd_q), MaxEdges);

  // Status.
  always_comb begin
    st_o.in_kind = KIND_NONE;
    case (req_type_i)
      REQ_COLOR:    st_o.in_kind = lt_v ? KIND_COLOR : KIND_RESULT;
      REQ_RD_COLOR: st_o.in_kind = KIND_RESULT;
      default:      st_o.in_kind = KIND_NONE;
    endcase
    st_o.clr_last    = clr_cnt_q == VW'(MaxVertices - 1);
    st_o.iv_lt_hi    = iv_q < hi1_q;
    st_o.iw_lt_hi    = iw_q < hi2_q;
    st_o.nb_valid    = nb_rd_q[NW-1];
    st_o.nb_is_u     = nb_rd_q[VW-1:0] == u_q;
    st_o.win_advance = full && (next_low <= 12'(COLOR_MAX));
    st_o.out_free    = !out_valid_q || out_ready_i;
  end

  // Memory port control.
  always_comb begin
    rs_we  = 1'b0; rs_re  = 1'b0; nb_we  = 1'b0; nb_re  = 1'b0;
    col_we = 1'b0; col_re = 1'b0;
    rs_wa  = idx32[RW-1:0];
    rs_wd  = value_i[RS_W-1:0];
    rs_ra  = RW'(u_q);
    nb_wa  = idx32[EW-1:0];
    nb_wd  = {val_nb_ok, val32[VW-1:0]};
    nb_ra  = iv_q[EW-1:0];
    col_wa = idx32[VW-1:0];
    col_wd = value_i[14] ? COLOR_NONE :
             (val32 > 32'(COLOR_MAX)) ? COLOR_MAX : value_i[COLOR_W-1:0];
    col_ra = idx32[VW-1:0];
    case (op_i)
      OP_CLEAR: begin
        col_we = 1'b1;
        col_wa = clr_cnt_q;
        col_wd = COLOR_NONE;
      end
      OP_ACCEPT: begin
        case (req_type_i)
          REQ_WR_ROW:   rs_we  = lt_r;
          REQ_WR_NB:    nb_we  = lt_e;
          REQ_WR_COLOR: col_we = lt_v;
          REQ_COLOR: begin
            rs_re = lt_v;
            rs_ra = idx32[RW-1:0];
          end
          REQ_RD_COLOR: col_re = lt_v;
          default: ;
        endcase
      end
      OP_RS_U1: begin
        rs_re = 1'b1;
        rs_ra = RW'(u_q) + RW'(1);
      end
      OP_NB1: nb_re = 1'b1;
      OP_NB1_DATA, OP_NB2_DATA: begin
        col_re = nb_rd_q[NW-1];
        col_ra = nb_rd_q[VW-1:0];
      end
      OP_V_COLOR: begin
        rs_re = 1'b1;
        rs_ra = RW'(v_q);
      end
      OP_RS_V1: begin
        rs_re = 1'b1;
        rs_ra = RW'(v_q) + RW'(1);
      end
      OP_NB2: begin
        nb_re = 1'b1;
        nb_ra = iw_q[EW-1:0];
      end
      OP_WINDOW: begin
        col_we = !st_o.win_advance;
        col_wa = u_q;
        col_wd = final_color;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rs_we) rs_mem[rs_wa] <= rs_wd;
    if (rs_re) rs_rd_q <= rs_mem[rs_ra];
  end

  always_ff @(posedge clk_i) begin
    if (nb_we) nb_mem[nb_wa] <= nb_wd;
    if (nb_re) nb_rd_q <= nb_mem[nb_ra];
  end

  always_ff @(posedge clk_i) begin
    if (col_we) col_mem[col_wa] <= col_wd;
    if (col_re) col_rd_q <= col_mem[col_ra];
  end

  // Walk registers and result payload.
  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_ACCEPT: begin
        u_q        <= idx32[VW-1:0];
        vtx_q      <= index_i[VTX_W-1:0];
        batch_q    <= (req_type_i == REQ_COLOR) ? last_i : 1'b0;
        from_mem_q <= (req_type_i == REQ_RD_COLOR) && lt_v;
        res_q      <= COLOR_NONE;
        low_q      <= '0;
        mask_q     <= '0;
      end
      OP_RS_U1: lo_raw_q <= rs_rd_q;
      OP_BOUNDS1: begin
        lo1_q <= CW'(min32(32'(lo_raw_q), b32));
        iv_q  <= CW'(min32(32'(lo_raw_q), b32));
        hi1_q <= CW'(b32);
      end
      OP_NB1_DATA: begin
        if (nb_rd_q[NW-1]) v_q <= nb_rd_q[VW-1:0];
        else iv_q <= iv_q + CW'(1);
      end
      OP_V_COLOR: mask_q <= mask_q | mark;
      OP_RS_V1:   lo_raw_q <= rs_rd_q;
      OP_BOUNDS2: begin
        iw_q  <= CW'(min32(32'(lo_raw_q), b32));
        hi2_q <= CW'(b32);
      end
      OP_NB2_DATA: begin
        if (!(nb_rd_q[NW-1] && nb_rd_q[VW-1:0] != u_q)) iw_q <= iw_q + CW'(1);
      end
      OP_W_COLOR: begin
        mask_q <= mask_q | mark;
        iw_q   <= iw_q + CW'(1);
      end
      OP_NEXT_V: iv_q <= iv_q + CW'(1);
      OP_WINDOW: begin
        if (st_o.win_advance) begin
          low_q  <= next_low[COLOR_W-1:0];
          mask_q <= '0;
          iv_q   <= lo1_q;
        end else begin
          res_q <= final_color;
        end
      end
      default: ;
    endcase
  end

  // Output valid register and clearing counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      clr_cnt_q   <= '0;
    end else begin
      if (op_i == OP_EMIT) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (op_i == OP_CLEAR) clr_cnt_q <= clr_cnt_q + VW'(1);
    end
  end

  logic [VTX_W-1:0]   ovtx_q;
  logic [COLOR_W-1:0] ocol_q;
  logic               obatch_q;
  always_ff @(posedge clk_i) begin
    if (op_i == OP_EMIT) begin
      ovtx_q   <= vtx_q;
      ocol_q   <= from_mem_q ? col_rd_q : res_q;
      obatch_q <= batch_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign vertex_o     = ovtx_q;
  assign color_o      = $signed(ocol_q);
  assign batch_done_o = obatch_q;

endmodule

// ===== design/distance_two_windowed_greedy_color_unit.sv =====
// ----------------------------------------------------------------------------
// distance_two_windowed_greedy_color_unit
// Distance-two greedy vertex colouring over a graph held in row-start form.
// ----------------------------------------------------------------------------
// A write word is stored as it is taken; a read word's colour is read into the
// read-data register, then copied into the output register once the output is free.
// A colour word walks the neighbours of every neighbour once per colour window;
// one memory port per store serialises the walk. The next word is taken as soon
// as the sequencer is back at rest. After reset the colour store is swept to
// uncoloured, entry by entry, during which no request word is taken.
module distance_two_windowed_greedy_color_unit import dtgc_pkg::*; #(
  parameter int unsigned MaxVertices = DTGC_MAX_VERTICES,
  parameter int unsigned MaxEdges    = DTGC_MAX_EDGES,
  parameter int unsigned Window      = DTGC_WINDOW
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dtgc_req_if.sink    req_i,
  dtgc_res_if.source  res_o
);

  // The sequencer and the datapath exchange only an operation code per cycle
  // and a status word; the memories and walk registers all sit in the datapath.
  dtgc_op_e     op;
  dtgc_status_t st;

  dtgc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .st_i       (st),
    .op_o       (op)
  );

  // The result word sits in an output register, so a new request word can be
  // taken while an earlier result still waits for the sink.
  dtgc_dp #(
    .MaxVertices (MaxVertices),
    .MaxEdges    (MaxEdges),
    .Window      (Window)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (op),
    .req_type_i   (req_i.req_type),
    .index_i      (req_i.index),
    .value_i      (req_i.value),
    .last_i       (req_i.last),
    .st_o         (st),
    .out_valid_o  (res_o.valid),
    .out_ready_i  (res_o.ready),
    .vertex_o     (res_o.vertex),
    .color_o      (res_o.color),
    .batch_done_o (res_o.batch_done)
  );

endmodule

// ===== design/dtgc_checker.sv =====
// ----------------------------------------------------------------------------
// dtgc_checker
// Port-level checks of the colouring unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dtgc_checker import dtgc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic [2:0]  req_type,
  input logic        out_valid,
  input logic        out_ready,
  input logic [10:0] color
);

  // Words that owe a result and have not yet delivered it.
  logic [1:0] pend_q;
  logic       give, take;
  assign give = in_valid && in_ready &&
                (req_type == REQ_COLOR || req_type == REQ_RD_COLOR);
  assign take = out_valid && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(give) - 2'(take);
    end
  end

  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid)
  `ASSERT_IMP(a_no_invented, clk_i, rst_ni, out_valid, pend_q != 2'd0)
  `ASSERT_IMP(a_pend_bound, clk_i, rst_ni, 1'b1, pend_q != 2'd3)
  `ASSERT_IMP(a_color_range, clk_i, rst_ni, out_valid, !color[10] || color == COLOR_NONE)

endmodule

bind distance_two_windowed_greedy_color_unit dtgc_checker u_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (req_i.valid),
  .in_ready  (req_i.ready),
  .req_type  (req_i.req_type),
  .out_valid (res_o.valid),
  .out_ready (res_o.ready),
  .color     (res_o.color)
);
